### rtl/core/fdf_pkg.sv
// shared constants, codes and types of the direct-form fir filter
package fdf_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int TAP_IDX_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int NUM_TAPS_W  = 7;
  localparam int COEFF_IDX_W = 6;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int ACC_W       = 40;
  localparam int FRAC_BITS   = 15;

  localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RST = NUM_TAPS_W'(64);

  typedef enum logic {
    ACT_FILTER = 1'b0,
    ACT_COEFF  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start_sample;
    logic write_coeff;
    logic issue;
    logic load_out;
  } fdf_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic fetch_idle;
    logic out_free;
  } fdf_sts_t;

endpackage

### rtl/core/fdf_in_if.sv
// input item channel: action, coefficient index and value
interface fdf_in_if import fdf_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [COEFF_IDX_W-1:0]        coeff_index;
  logic signed [SAMPLE_W-1:0]    value;

  modport source (output valid, output action, output coeff_index, output value,
                  input ready);
  modport sink   (input valid, input action, input coeff_index, input value,
                  output ready);
endinterface

### rtl/core/fdf_out_if.sv
// result item channel: filtered sample and saturation flag
interface fdf_out_if import fdf_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_W-1:0]    filtered;
  logic                          saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

### rtl/core/fdf_cfg_if.sv
// configuration write channel for the tap count register
interface fdf_cfg_if import fdf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NUM_TAPS_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/fir_filter_direct_form_unit.sv
// top level of the direct-form fir filter with circular delay line
// a sample item: accepted in idle, taps issued in run, mac pipeline emptied in drain,
// result loaded in out once the output register is free; no new item until back in idle
// coefficient items are taken only in idle and give no result; a single shared mac walks the taps
// reset: rst_n low clears tap count to 64, write position, store valid bits and handshakes
// no clearing pass: unwritten delay and coefficient entries read as zero via valid bits
module fir_filter_direct_form_unit import fdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  fdf_in_if.sink   in_ch,
  fdf_out_if.source out_ch,
  fdf_cfg_if.sink  cfg_ch
);

  logic [NUM_TAPS_W-1:0] num_taps_r;
  fdf_cmd_t              cmd;
  fdf_sts_t              sts;

  // tap count register, always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_taps_r <= NUM_TAPS_RST;
    end else if (cfg_ch.valid) begin
      num_taps_r <= cfg_ch.data;
    end
  end

  // controller: accepts items in idle, walks the taps, hands over the result
  fdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: stores, pointer logic, mac pipeline and output register
  fdf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .num_taps       (num_taps_r),
    .in_coeff_index (in_ch.coeff_index),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_filtered   (out_ch.filtered),
    .out_saturated  (out_ch.saturated)
  );

endmodule

### rtl/core/fdf_ctrl.sv
// sequencing state machine of the fir filter
module fdf_ctrl import fdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  output logic     in_ready,
  input  fdf_sts_t sts,
  output fdf_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_action == ACT_FILTER)) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.fetch_idle) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.start_sample = in_valid && (in_action == ACT_FILTER);
        cmd.write_coeff  = in_valid && (in_action == ACT_COEFF);
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_OUT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && sts.last_issue) |=> (state_r == ST_DRAIN))
    else $error("tap loop did not end after last tap");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !sts.out_free) |=> (state_r == ST_OUT))
    else $error("result dropped while output register busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one command at once");

endmodule

### rtl/core/fdf_datapath.sv
// delay line, coefficient store, multiply-accumulate and output register
module fdf_datapath import fdf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fdf_cmd_t                    cmd,
  output fdf_sts_t                    sts,
  input  logic [NUM_TAPS_W-1:0]       num_taps,
  input  logic [COEFF_IDX_W-1:0]      in_coeff_index,
  input  logic signed [SAMPLE_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_filtered,
  output logic                        out_saturated
);

  localparam int TOP_W = ACC_W - (FRAC_BITS + SAMPLE_W - 1);

  logic [SAMPLE_W-1:0]  delay_mem [MAX_TAPS];
  logic [SAMPLE_W-1:0]  coeff_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]  delay_vld_r;
  logic [MAX_TAPS-1:0]  coeff_vld_r;

  logic [TAP_IDX_W-1:0] write_pos_r;
  logic [TAP_IDX_W-1:0] pos_r;
  logic [TAP_CNT_W-1:0] n_r;
  logic [TAP_IDX_W-1:0] tap_r;
  logic [TAP_IDX_W-1:0] rd_p_r;

  logic [SAMPLE_W-1:0]  coeff_q_r;
  logic [SAMPLE_W-1:0]  delay_q_r;
  logic                 coeff_qv_r;
  logic                 delay_qv_r;
  logic                 rd_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                 prod_v_r;
  logic [ACC_W-1:0]     acc_r;

  logic                 out_valid_r;
  logic signed [SAMPLE_W-1:0] filtered_r;
  logic                 saturated_r;

  logic [TAP_CNT_W-1:0] n_eff;
  logic [TAP_IDX_W-1:0] start_pos;
  logic                 coeff_in_range;
  logic [TAP_IDX_W-1:0] coeff_addr;
  logic signed [SAMPLE_W-1:0] coeff_op;
  logic signed [SAMPLE_W-1:0] delay_op;
  logic [TOP_W-1:0]     acc_top;
  logic                 sat;
  logic signed [SAMPLE_W-1:0] sat_val;

  // zero taps act as one, too many act as the maximum
  always_comb begin
    if (num_taps == '0) begin
      n_eff = TAP_CNT_W'(1);
    end else if (int'(num_taps) > MAX_TAPS) begin
      n_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      n_eff = TAP_CNT_W'(num_taps);
    end
  end

  assign start_pos      = (TAP_CNT_W'(write_pos_r) >= n_eff) ? '0 : write_pos_r;
  assign coeff_in_range = int'(in_coeff_index) < MAX_TAPS;
  assign coeff_addr     = TAP_IDX_W'(in_coeff_index);

  // stores: never-written entries read back as zero through the valid bits
  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      delay_mem[start_pos] <= in_value;
    end
    if (cmd.issue) begin
      delay_q_r <= delay_mem[rd_p_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_coeff && coeff_in_range) begin
      coeff_mem[coeff_addr] <= in_value;
    end
    if (cmd.issue) begin
      coeff_q_r <= coeff_mem[tap_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_vld_r <= '0;
      coeff_vld_r <= '0;
    end else begin
      if (cmd.start_sample) delay_vld_r[start_pos] <= 1'b1;
      if (cmd.write_coeff && coeff_in_range) coeff_vld_r[coeff_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      delay_qv_r <= delay_vld_r[rd_p_r];
      coeff_qv_r <= coeff_vld_r[tap_r];
    end
  end

  // tap and delay pointers
  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      n_r    <= n_eff;
      pos_r  <= start_pos;
      tap_r  <= '0;
      rd_p_r <= start_pos;
    end else if (cmd.issue) begin
      tap_r  <= tap_r + 1'b1;
      rd_p_r <= (TAP_CNT_W'(rd_p_r) == n_r - TAP_CNT_W'(1)) ? '0 : rd_p_r + 1'b1;
    end
  end

  assign coeff_op = coeff_qv_r ? coeff_q_r : '0;
  assign delay_op = delay_qv_r ? delay_q_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coeff_op * delay_op;
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // shift right by the fraction bits, then clip to the sample range
  assign acc_top = acc_r[ACC_W-1:FRAC_BITS+SAMPLE_W-1];
  assign sat     = !((&acc_top) || !(|acc_top));
  assign sat_val = acc_r[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        write_pos_r <= (pos_r == '0) ? TAP_IDX_W'(n_r - TAP_CNT_W'(1)) : pos_r - 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered_r  <= sat ? sat_val : acc_r[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
      saturated_r <= sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = filtered_r;
  assign out_saturated = saturated_r;

  assign sts.last_issue = TAP_CNT_W'(tap_r) == n_r - TAP_CNT_W'(1);
  assign sts.fetch_idle = !rd_v_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  a_start_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_sample |-> (!rd_v_r && !prod_v_r))
    else $error("sample started with taps still in flight");

  a_load_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!rd_v_r && !prod_v_r))
    else $error("result loaded before accumulation finished");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (TAP_CNT_W'(tap_r) < n_r))
    else $error("tap index ran past tap count");

endmodule
